### design/status_led_color_blinker_macros.svh
// ----------------------------------------------------------------------------
// status_led_color_blinker_macros.svh
// Assertion helpers for the status LED color blinker (clk / rst in scope).
// ----------------------------------------------------------------------------
`ifndef STATUS_LED_COLOR_BLINKER_MACROS_SVH
`define STATUS_LED_COLOR_BLINKER_MACROS_SVH

// same-cycle implication
`define SLCB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SLCB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/slcb_pkg.sv
// ----------------------------------------------------------------------------
// slcb_pkg
// Shared types, status codes, color table and helpers for the LED blinker.
// ----------------------------------------------------------------------------
package slcb_pkg;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int NOW_WIDTH       = 32;
  localparam int STATUS_WIDTH    = 3;
  localparam int COLOR_WIDTH     = 8;
  localparam int PERIOD_WIDTH    = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 16;
  localparam int HUE_WIDTH       = 9;
  localparam int HALF_WIDTH      = 11;
  localparam int SECTOR_WIDTH    = 3;
  localparam int FRAC_WIDTH      = 8;
  localparam int PROD_WIDTH      = 16;
  localparam int DIV_N_WIDTH     = 32;
  localparam int DIV_D_WIDTH     = 16;

  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd8000;
  localparam logic [COLOR_WIDTH-1:0]  BRIGHT_RESET = 8'd50;
  localparam logic [DIV_N_WIDTH-1:0]  DEG_PER_TURN = 32'd360;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MOOD_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MOOD_BRIGHT = 2'd1;

  // status codes
  localparam logic [STATUS_WIDTH-1:0] STATUS_BOOTING    = 3'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_IDLE       = 3'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_WIFI       = 3'd2;
  localparam logic [STATUS_WIDTH-1:0] STATUS_LOGGING    = 3'd3;
  localparam logic [STATUS_WIDTH-1:0] STATUS_SD_ERR     = 3'd4;
  localparam logic [STATUS_WIDTH-1:0] STATUS_SENSOR_ERR = 3'd5;
  localparam logic [STATUS_WIDTH-1:0] STATUS_SENSOR_DIS = 3'd6;
  localparam logic [STATUS_WIDTH-1:0] STATUS_SLEEPING   = 3'd7;

  // color wheel sectors, 60 degrees each
  localparam logic [SECTOR_WIDTH-1:0] SECTOR_RED_YEL = 3'd0;
  localparam logic [SECTOR_WIDTH-1:0] SECTOR_YEL_GRN = 3'd1;
  localparam logic [SECTOR_WIDTH-1:0] SECTOR_GRN_CYN = 3'd2;
  localparam logic [SECTOR_WIDTH-1:0] SECTOR_CYN_BLU = 3'd3;
  localparam logic [SECTOR_WIDTH-1:0] SECTOR_BLU_MAG = 3'd4;
  localparam int NUM_SECTORS = 6;
  localparam logic [HUE_WIDTH-1:0] SECTOR_BASE [NUM_SECTORS] =
    '{9'd0, 9'd60, 9'd120, 9'd180, 9'd240, 9'd300};

  typedef struct packed {
    logic [COLOR_WIDTH-1:0] r;
    logic [COLOR_WIDTH-1:0] g;
    logic [COLOR_WIDTH-1:0] b;
  } rgb_t;

  typedef struct packed {
    rgb_t                  color;
    logic                  blinks;
    logic [HALF_WIDTH-1:0] half;
  } status_look_t;

  function automatic status_look_t status_lookup(input logic [STATUS_WIDTH-1:0] st);
    status_look_t lk;
    lk = '0;
    case (st)
      STATUS_BOOTING:    lk = '{color: '{8'd30, 8'd30, 8'd30}, blinks: 1'b0, half: 11'd0};
      STATUS_IDLE:       lk = '{color: '{8'd0,  8'd0,  8'd0},  blinks: 1'b0, half: 11'd0};
      STATUS_WIFI:       lk = '{color: '{8'd0,  8'd0,  8'd60}, blinks: 1'b1, half: 11'd300};
      STATUS_LOGGING:    lk = '{color: '{8'd0,  8'd60, 8'd0},  blinks: 1'b1, half: 11'd500};
      STATUS_SD_ERR:     lk = '{color: '{8'd60, 8'd0,  8'd0},  blinks: 1'b1, half: 11'd150};
      STATUS_SENSOR_ERR: lk = '{color: '{8'd60, 8'd0,  8'd60}, blinks: 1'b1, half: 11'd150};
      STATUS_SENSOR_DIS: lk = '{color: '{8'd60, 8'd0,  8'd0},  blinks: 1'b0, half: 11'd0};
      default:           lk = '{color: '{8'd80, 8'd30, 8'd0},  blinks: 1'b1, half: 11'd1500};
    endcase
    return lk;
  endfunction

  // floor(x / 255), exact for x up to 255*255
  function automatic logic [COLOR_WIDTH-1:0] div255(input logic [PROD_WIDTH-1:0] x);
    logic [PROD_WIDTH:0] s;
    s = (PROD_WIDTH+1)'(x) + (PROD_WIDTH+1)'(x >> 8) + (PROD_WIDTH+1)'(1);
    return s[PROD_WIDTH-1:COLOR_WIDTH];
  endfunction

endpackage

### design/status_led_color_blinker.sv
// Sequence: an idle-status request goes from accept through evaluate, two shared-divider
//   passes, hue conversion and output load to out_valid; others go from evaluate to output load.
// A new request is taken only after the previous result is loaded into the output
//   register, so the divider paces requests in idle status.
// Reset (rst, synchronous): registers to 8000 ms / 50, status booting, phase on,
//   toggle time 0, no result pending.
// ----------------------------------------------------------------------------
// status_led_color_blinker
// Status LED color generator: hue sweep in idle status, fixed or blinking
// colors for every other status.
// ----------------------------------------------------------------------------
`include "status_led_color_blinker_macros.svh"

module status_led_color_blinker #(
  parameter int TIME_WIDTH = slcb_pkg::TIME_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [slcb_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [slcb_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
  // update requests
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [slcb_pkg::STATUS_WIDTH-1:0]      status,
  input  logic [slcb_pkg::NOW_WIDTH-1:0]         now_ms,
  // colors
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [slcb_pkg::COLOR_WIDTH-1:0]       red,
  output logic [slcb_pkg::COLOR_WIDTH-1:0]       green,
  output logic [slcb_pkg::COLOR_WIDTH-1:0]       blue
);

  localparam int NW   = slcb_pkg::DIV_N_WIDTH;
  localparam int DW   = slcb_pkg::DIV_D_WIDTH;
  localparam int HW   = slcb_pkg::HUE_WIDTH;
  localparam int PERW = slcb_pkg::PERIOD_WIDTH;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] ST_EVAL = 3'd1;  // status change, blink timing
  localparam logic [2:0] ST_DIV1 = 3'd2;  // now mod period
  localparam logic [2:0] ST_DIV2 = 3'd3;  // remainder * 360 / period
  localparam logic [2:0] ST_HSV  = 3'd4;  // hue to RGB
  localparam logic [2:0] ST_OUT  = 3'd5;  // hand result to output register

  logic [2:0] state;
  logic [2:0] state_next;

  // configuration
  logic [slcb_pkg::PERIOD_WIDTH-1:0] mood_period_ms;
  logic [slcb_pkg::COLOR_WIDTH-1:0]  sweep_value;
  logic [slcb_pkg::PERIOD_WIDTH-1:0] period_eff;

  // blink state
  logic [slcb_pkg::STATUS_WIDTH-1:0] prev_status;
  logic                              phase_on;
  logic [TIME_WIDTH-1:0]             last_toggle;

  // captured request
  logic [slcb_pkg::STATUS_WIDTH-1:0] st_q;
  logic [TIME_WIDTH-1:0]             now_q;

  // evaluation
  logic                   chg;
  logic                   phase_eff;
  logic [TIME_WIDTH-1:0]  last_eff;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic                   toggle;
  logic                   phase_new;
  logic [TIME_WIDTH-1:0]  last_new;
  slcb_pkg::status_look_t look;

  slcb_pkg::rgb_t res;
  slcb_pkg::rgb_t hsv_rgb;

  // shared divider
  logic          div_start;
  logic [NW-1:0] div_dividend;
  logic          div_done;
  logic [NW-1:0] div_quo;
  logic [DW-1:0] div_rem;
  logic          div_pass;

  logic          hsv_start;
  logic          hsv_done;
  logic          out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign div_pass  = (state == ST_DIV1) || (state == ST_DIV2);

  // a zero period behaves as one, which pins the hue at zero
  assign period_eff = (mood_period_ms == '0) ? PERW'(1) : mood_period_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      mood_period_ms <= slcb_pkg::PERIOD_RESET;
      sweep_value    <= slcb_pkg::BRIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == slcb_pkg::CFG_MOOD_PERIOD) begin
        mood_period_ms <= cfg_data;
      end else if (cfg_index == slcb_pkg::CFG_MOOD_BRIGHT) begin
        sweep_value <= cfg_data[slcb_pkg::COLOR_WIDTH-1:0];
      end
    end
  end

  // A status change restarts blinking in the on phase at the current time,
  // then a blinking status flips phase once its half-period has elapsed.
  // Elapsed time wraps at the time width.
  always_comb begin
    chg       = (st_q != prev_status);
    phase_eff = chg ? 1'b1 : phase_on;
    last_eff  = chg ? now_q : last_toggle;
    look      = slcb_pkg::status_lookup(st_q);
    elapsed   = now_q - last_eff;
    toggle    = look.blinks && (elapsed >= TIME_WIDTH'(look.half));
    phase_new = toggle ? !phase_eff : phase_eff;
    last_new  = toggle ? now_q : last_eff;
  end

  // Pass one: now (at most 32 bits) mod period.
  // Pass two: remainder * 360 / period, quotient below 360.
  assign div_start    = ((state == ST_EVAL) && (st_q == slcb_pkg::STATUS_IDLE)) ||
                        ((state == ST_DIV1) && div_done);
  assign div_dividend = (state == ST_EVAL) ? NW'(now_q)
                                           : NW'(div_rem) * slcb_pkg::DEG_PER_TURN;
  assign hsv_start    = (state == ST_DIV2) && div_done;
  assign out_load     = (state == ST_OUT) && (!out_valid || out_ready);

  slcb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (period_eff),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  slcb_hsv u_hsv (
    .clk   (clk),
    .rst   (rst),
    .start (hsv_start),
    .hue   (div_quo[HW-1:0]),
    .val   (sweep_value),
    .done  (hsv_done),
    .rgb   (hsv_rgb)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid) state_next = ST_EVAL;
      ST_EVAL: state_next = (st_q == slcb_pkg::STATUS_IDLE) ? ST_DIV1 : ST_OUT;
      ST_DIV1: if (div_done) state_next = ST_DIV2;
      ST_DIV2: if (div_done) state_next = ST_HSV;
      ST_HSV:  if (hsv_done) state_next = ST_OUT;
      ST_OUT:  if (out_load) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      prev_status <= slcb_pkg::STATUS_BOOTING;
      phase_on    <= 1'b1;
      last_toggle <= '0;
    end else begin
      state <= state_next;
      if (state == ST_EVAL) begin
        prev_status <= st_q;
        phase_on    <= phase_new;
        last_toggle <= last_new;
      end
    end
  end

  // request capture and result holding
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      st_q  <= status;
      now_q <= TIME_WIDTH'(now_ms);
    end
    if (state == ST_EVAL) begin
      res <= (look.blinks && !phase_new) ? '0 : look.color;
    end else if ((state == ST_HSV) && hsv_done) begin
      res <= hsv_rgb;
    end
  end

  // output register: a finished color may wait here while the next request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      red   <= res.r;
      green <= res.g;
      blue  <= res.b;
    end
  end

  // checks
  `SLCB_ASSERT_SAME(a_div_done_in_pass, div_done, div_pass, "divider done outside a pass")
  `SLCB_ASSERT_SAME(a_hsv_done_in_conv, hsv_done, state == ST_HSV, "hue done outside conversion")
  `SLCB_ASSERT_NEXT(a_accept_eval, in_valid && in_ready, state == ST_EVAL, "no evaluation")
  `SLCB_ASSERT_NEXT(a_prev_status, state == ST_EVAL, prev_status == $past(st_q), "stale status")

endmodule

### design/slcb_div.sv
// ----------------------------------------------------------------------------
// slcb_div
// Restoring divider, one quotient bit per cycle, shared by both idle passes.
// ----------------------------------------------------------------------------
module slcb_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [slcb_pkg::DIV_N_WIDTH-1:0]   dividend,
  input  logic [slcb_pkg::DIV_D_WIDTH-1:0]   divisor,
  output logic                               done,
  output logic [slcb_pkg::DIV_N_WIDTH-1:0]   quotient,
  output logic [slcb_pkg::DIV_D_WIDTH-1:0]   remainder
);

  localparam int NW = slcb_pkg::DIV_N_WIDTH;
  localparam int DW = slcb_pkg::DIV_D_WIDTH;
  localparam int CW = $clog2(NW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] quo;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - (DW+1)'(dvs);
  assign fits  = trial >= (DW+1)'(dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == CW'(NW - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[NW-2:0], fits};
      rem <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### design/slcb_hsv.sv
// ----------------------------------------------------------------------------
// slcb_hsv
// Two-stage full-saturation hue to RGB conversion (sector, fraction, scale).
// ----------------------------------------------------------------------------
module slcb_hsv (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [slcb_pkg::HUE_WIDTH-1:0]      hue,
  input  logic [slcb_pkg::COLOR_WIDTH-1:0]    val,
  output logic                                done,
  output slcb_pkg::rgb_t                      rgb
);

  localparam int SW = slcb_pkg::SECTOR_WIDTH;
  localparam int FW = slcb_pkg::FRAC_WIDTH;
  localparam int VW = slcb_pkg::COLOR_WIDTH;
  localparam int PW = slcb_pkg::PROD_WIDTH;

  logic [SW-1:0] sector;
  logic [5:0]    offs;
  logic [FW-1:0] frac;

  logic          v1;
  logic [SW-1:0] sector1;
  logic [FW-1:0] frac1;
  logic [VW-1:0] val1;

  logic          v2;
  logic [SW-1:0] sector2;
  logic [VW-1:0] val2;
  logic [PW-1:0] q_prod;
  logic [PW-1:0] t_prod;

  logic [VW-1:0] q;
  logic [VW-1:0] t;

  // sector and position within it; 255/60 reduces to 17/4
  always_comb begin
    sector = slcb_pkg::SECTOR_RED_YEL;
    for (int k = 1; k < slcb_pkg::NUM_SECTORS; k++) begin
      if (hue >= slcb_pkg::SECTOR_BASE[k]) sector = SW'(k);
    end
    offs = 6'(hue - slcb_pkg::SECTOR_BASE[sector]);
    frac = FW'((10'(offs) * 10'd17) >> 2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sector1 <= sector;
      frac1   <= frac;
      val1    <= val;
    end
    if (v1) begin
      sector2 <= sector1;
      val2    <= val1;
      q_prod  <= PW'(val1) * PW'(8'd255 - frac1);
      t_prod  <= PW'(val1) * PW'(frac1);
    end
  end

  assign q    = slcb_pkg::div255(q_prod);
  assign t    = slcb_pkg::div255(t_prod);
  assign done = v2;

  always_comb begin
    case (sector2)
      slcb_pkg::SECTOR_RED_YEL: rgb = '{val2, t, 8'd0};
      slcb_pkg::SECTOR_YEL_GRN: rgb = '{q, val2, 8'd0};
      slcb_pkg::SECTOR_GRN_CYN: rgb = '{8'd0, val2, t};
      slcb_pkg::SECTOR_CYN_BLU: rgb = '{8'd0, q, val2};
      slcb_pkg::SECTOR_BLU_MAG: rgb = '{t, 8'd0, val2};
      default:                  rgb = '{val2, 8'd0, q};
    endcase
  end

endmodule
